/* rtl/core/esd_pkg.sv */
`default_nettype none

package esd_pkg;

  // decoder modes, one-hot
  typedef enum logic [5:0] {
    MODE_PLAIN   = 6'b000001,
    MODE_ESC     = 6'b000010,
    MODE_HEX     = 6'b000100,
    MODE_UNI     = 6'b001000,
    MODE_OCT     = 6'b010000,
    MODE_DISCARD = 6'b100000
  } mode_e;

  // result error codes
  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_TRAILING = 2'd1,
    ERR_FORMAT   = 2'd2
  } err_e;

  localparam logic [7:0] EscReset  = 8'h5C;
  localparam logic [7:0] CharHex   = 8'h78;  // 'x'
  localparam logic [7:0] CharUni   = 8'h75;  // 'u'
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  // input request
  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_req_t;

  // output request
  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
    err_e       error_code;
  } out_req_t;

  // one decoded job between front and back
  typedef struct packed {
    logic [15:0] value;
    logic        utf8;
    logic        last;
    err_e        err;
  } job_t;

  // queue status seen by both ends
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  typedef struct packed {
    logic       ok;
    logic [7:0] val;
  } sesc_t;

  // hex digit, either case
  function automatic hex_t hex_digit(input logic [7:0] c);
    hex_t r;
    r.ok  = 1'b0;
    r.val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r.ok  = 1'b1;
      r.val = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r.ok  = 1'b1;
      r.val = c[3:0] + 4'd9;
    end
    return r;
  endfunction

  // single-character escapes
  function automatic sesc_t single_escape(input logic [7:0] c);
    sesc_t r;
    r.ok  = 1'b1;
    r.val = c;
    case (c)
      8'h20, 8'h22, 8'h27, 8'h3F, 8'h5C: r.val = c;
      8'h61:   r.val = 8'd7;
      8'h62:   r.val = 8'd8;
      8'h66:   r.val = 8'd12;
      8'h6E:   r.val = 8'd10;
      8'h72:   r.val = 8'd13;
      8'h74:   r.val = 8'd9;
      8'h76:   r.val = 8'd11;
      default: r.ok = 1'b0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/esd_front.sv */
`default_nettype none

module esd_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_we_i,
  input  wire logic [7:0]      cfg_wdata_i,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire esd_pkg::in_req_t in_req_i,
  input  wire esd_pkg::q_stat_t q_stat_i,
  output logic                 push_o,
  output esd_pkg::job_t        job_o
);

  logic [7:0]     esc_q;
  esd_pkg::mode_e mode_q, mode_d;
  logic [1:0]     digits_q, digits_d;
  logic [15:0]    code_q, code_d;

  logic           accept;
  logic           err_hit;
  esd_pkg::err_e  err_kind;
  esd_pkg::hex_t  hex_c;
  esd_pkg::sesc_t sgl_c;
  logic           oct_ok;
  logic [15:0]    hex_code;
  logic [15:0]    oct_code;
  logic [7:0]     c;
  logic           last;

  assign in_stall_o = q_stat_i.full;
  assign accept     = in_valid_i && !q_stat_i.full;
  assign c          = in_req_i.in_byte;
  assign last       = in_req_i.in_last;

  // escape character register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_q <= esd_pkg::EscReset;
    end else if (cfg_we_i) begin
      esc_q <= cfg_wdata_i;
    end
  end

  // digit classification
  always_comb begin
    hex_c    = esd_pkg::hex_digit(c);
    sgl_c    = esd_pkg::single_escape(c);
    oct_ok   = (c[7:3] == 5'b00110);
    hex_code = {code_q[11:0], hex_c.val};
    oct_code = {7'd0, code_q[5:0], c[2:0]};
  end

  // decode step
  always_comb begin
    mode_d    = mode_q;
    digits_d  = digits_q;
    code_d    = code_q;
    push_o    = 1'b0;
    job_o.value = {8'd0, c};
    job_o.utf8  = 1'b0;
    job_o.last  = last;
    job_o.err   = esd_pkg::ERR_NONE;
    err_hit   = 1'b0;
    err_kind  = esd_pkg::ERR_FORMAT;
    if (accept) begin
      case (mode_q)
        esd_pkg::MODE_PLAIN: begin
          if (c == esc_q) begin
            if (last) begin
              err_hit  = 1'b1;
              err_kind = esd_pkg::ERR_TRAILING;
            end else begin
              mode_d = esd_pkg::MODE_ESC;
            end
          end else begin
            push_o = 1'b1;
          end
        end
        esd_pkg::MODE_ESC: begin
          if (sgl_c.ok) begin
            push_o      = 1'b1;
            job_o.value = {8'd0, sgl_c.val};
            mode_d      = esd_pkg::MODE_PLAIN;
          end else if (c == esd_pkg::CharHex || c == esd_pkg::CharUni) begin
            if (last) begin
              err_hit = 1'b1;
            end else begin
              mode_d   = (c == esd_pkg::CharHex) ? esd_pkg::MODE_HEX : esd_pkg::MODE_UNI;
              digits_d = 2'd0;
              code_d   = 16'd0;
            end
          end else if (!oct_ok || last) begin
            err_hit = 1'b1;
          end else begin
            mode_d   = esd_pkg::MODE_OCT;
            digits_d = 2'd1;
            code_d   = {13'd0, c[2:0]};
          end
        end
        esd_pkg::MODE_HEX, esd_pkg::MODE_UNI: begin
          if (!hex_c.ok) begin
            err_hit = 1'b1;
          end else if (mode_q == esd_pkg::MODE_HEX && digits_q == 2'd1) begin
            push_o      = 1'b1;
            job_o.value = hex_code;
            mode_d      = esd_pkg::MODE_PLAIN;
            digits_d    = 2'd0;
            code_d      = hex_code;
          end else if (mode_q == esd_pkg::MODE_UNI && digits_q == 2'd3) begin
            push_o      = 1'b1;
            job_o.value = hex_code;
            job_o.utf8  = 1'b1;
            mode_d      = esd_pkg::MODE_PLAIN;
            digits_d    = 2'd0;
            code_d      = hex_code;
          end else if (last) begin
            err_hit = 1'b1;
          end else begin
            digits_d = digits_q + 2'd1;
            code_d   = hex_code;
          end
        end
        esd_pkg::MODE_OCT: begin
          if (!oct_ok) begin
            err_hit = 1'b1;
          end else if (digits_q == 2'd2) begin
            push_o      = 1'b1;
            job_o.value = oct_code;
            mode_d      = esd_pkg::MODE_PLAIN;
            digits_d    = 2'd0;
            code_d      = oct_code;
          end else if (last) begin
            err_hit = 1'b1;
          end else begin
            digits_d = digits_q + 2'd1;
            code_d   = oct_code;
          end
        end
        esd_pkg::MODE_DISCARD: begin
          if (last) begin
            mode_d = esd_pkg::MODE_PLAIN;
          end
        end
        default: begin
          mode_d = esd_pkg::MODE_PLAIN;
        end
      endcase
    end

    // error result, then drop the rest of the argument
    if (err_hit) begin
      push_o      = 1'b1;
      job_o.value = 16'd0;
      job_o.utf8  = 1'b0;
      job_o.last  = 1'b1;
      job_o.err   = err_kind;
      mode_d      = last ? esd_pkg::MODE_PLAIN : esd_pkg::MODE_DISCARD;
      digits_d    = 2'd0;
      code_d      = 16'd0;
    end
  end

  // decoder state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= esd_pkg::MODE_PLAIN;
      digits_q <= 2'd0;
      code_q   <= 16'd0;
    end else begin
      mode_q   <= mode_d;
      digits_q <= digits_d;
      code_q   <= code_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/esd_queue.sv */
`default_nettype none

module esd_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire esd_pkg::job_t  push_data_i,
  input  wire logic           pop_i,
  output esd_pkg::job_t       head_o,
  output esd_pkg::q_stat_t    stat_o
);

  esd_pkg::job_t                      mem_q [esd_pkg::QueueDepth];
  logic [esd_pkg::QueuePtrW-1:0]      wr_ptr_q, rd_ptr_q;
  logic [esd_pkg::QueueCntW-1:0]      cnt_q, cnt_d;
  logic                               do_push, do_pop;

  assign stat_o.full  = (cnt_q == esd_pkg::QueueCntW'(esd_pkg::QueueDepth));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign head_o       = mem_q[rd_ptr_q];

  // occupancy
  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  // pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_d;
    end
  end

  // job storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/esd_back.sv */
`default_nettype none

module esd_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire esd_pkg::job_t    head_i,
  input  wire esd_pkg::q_stat_t q_stat_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output esd_pkg::out_req_t     out_req_o
);

  logic              out_valid_q;
  esd_pkg::out_req_t out_q, out_d;
  logic [1:0]        idx_q;
  logic [1:0]        last_idx;
  logic              load, take;
  logic [15:0]       v;

  assign v           = head_i.value;
  assign load        = !out_valid_q || !out_stall_i;
  assign take        = load && !q_stat_i.empty;
  assign pop_o       = take && (idx_q == last_idx);
  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

  // last byte index of the head job
  always_comb begin
    if (!head_i.utf8 || v < 16'h0080) begin
      last_idx = 2'd0;
    end else if (v < 16'h0800) begin
      last_idx = 2'd1;
    end else begin
      last_idx = 2'd2;
    end
  end

  // select the current byte of the expansion
  always_comb begin
    out_d.out_last   = head_i.last && (idx_q == last_idx);
    out_d.error_code = head_i.err;
    out_d.out_byte   = v[7:0];
    case (last_idx)
      2'd1: begin
        out_d.out_byte = (idx_q == 2'd0) ? {3'b110, v[10:6]} : {2'b10, v[5:0]};
      end
      2'd2: begin
        case (idx_q)
          2'd0:    out_d.out_byte = {4'b1110, v[15:12]};
          2'd1:    out_d.out_byte = {2'b10, v[11:6]};
          default: out_d.out_byte = {2'b10, v[5:0]};
        endcase
      end
      default: begin
        out_d.out_byte = v[7:0];
      end
    endcase
  end

  // output register and byte index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= 2'd0;
    end else if (load) begin
      out_valid_q <= take;
      if (take) begin
        idx_q <= (idx_q == last_idx) ? 2'd0 : idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_q <= out_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/escape_sequence_decoder.sv */
`default_nettype none

// Escape sequence decoder: takes one argument byte per cycle (in_last on its final
// byte) and returns the decoded bytes, with \x, \u (as 1 to 3 UTF-8 bytes), octal
// and single-character escapes, and one error result for a malformed sequence.
// A byte is accepted every cycle while the four-entry job queue has room; each
// result passes through the job queue into the output register. The output side
// gives one byte per cycle while out_stall_i is low; a \u value of two or three
// bytes holds the output while the queue absorbs input. The user must write the
// escape character via cfg_we_i/cfg_wdata_i while idle; the block doesn't check.

module escape_sequence_decoder (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [7:0]        cfg_wdata_i,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire esd_pkg::in_req_t  in_req_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output esd_pkg::out_req_t      out_req_o
);

  logic             push, pop;
  esd_pkg::job_t    push_job, head_job;
  esd_pkg::q_stat_t q_stat;

  // classify and decode input bytes
  esd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .q_stat_i    (q_stat),
    .push_o      (push),
    .job_o       (push_job)
  );

  // job queue
  esd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .pop_i       (pop),
    .head_o      (head_job),
    .stat_o      (q_stat)
  );

  // emit result bytes
  esd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head_job),
    .q_stat_i    (q_stat),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_req_o   (out_req_o)
  );

endmodule

`default_nettype wire

/* rtl/core/esd_checker.sv */
`default_nettype none

module esd_checker (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_stall_o,
  input wire logic              out_valid_o,
  input wire logic              out_stall_i,
  input wire esd_pkg::out_req_t out_req_o
);

  // a stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // an error result carries a zero byte and closes the argument
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_req_o.error_code != esd_pkg::ERR_NONE |->
      out_req_o.out_byte == 8'd0 && out_req_o.out_last)
    else $error("error result with data or without last");

  // nothing is offered right out of reset
  assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result valid right after reset");

  // a stalled input request stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i)
    else $error("input request withdrawn while stalled");

endmodule

bind escape_sequence_decoder esd_checker u_esd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_req_o   (out_req_o)
);

`default_nettype wire
